// ===== src/vpm_pkg.sv =====
// Package for the vector pattern matcher: field widths, function and
// register codes, and the command type passed from front end to back end.
// No dependencies.
`default_nettype none

package vpm_pkg;

   localparam int FUNC_W      = 2;
   localparam int INDEX_W     = 6;
   localparam int VALUE_W     = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 9;
   localparam int DIM_REG_W   = 9;
   localparam int LEN_REG_W   = 7;
   localparam int OCC_W       = 16;
   localparam int POS_OUT_W   = 8;

   // Function codes carried on the request channel.
   localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ELEM  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_ROWS    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_COLS    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LEN = 2'd2;

   localparam logic [DIM_REG_W-1:0] NUM_ROWS_RESET    = 9'd256;
   localparam logic [DIM_REG_W-1:0] NUM_COLS_RESET    = 9'd256;
   localparam logic [LEN_REG_W-1:0] PATTERN_LEN_RESET = 7'd1;

   typedef enum logic [1:0] {
      OP_WRITE,
      OP_ELEM,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      op_type                    op;
      logic [INDEX_W-1:0]        word_index;
      logic signed [VALUE_W-1:0] word_value;
   } cmd_type;

endpackage

`default_nettype wire

// ===== src/vpm_front.sv =====
// Front end of the pattern matcher: accepts request items, decodes the
// function code and holds one classified command. Uses vpm_pkg.
`default_nettype none

module vpm_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [vpm_pkg::FUNC_W-1:0]     req_func,
   input  wire logic [vpm_pkg::INDEX_W-1:0]    req_word_index,
   input  wire logic signed [vpm_pkg::VALUE_W-1:0] req_word_value,
   output logic                                out_valid,
   input  wire logic                           out_ready,
   output vpm_pkg::cmd_type                    out_cmd
);

   logic             valid_ff, valid_in;
   vpm_pkg::cmd_type cmd_ff, cmd_in;
   logic             keep;

   assign req_ready = !valid_ff || out_ready;

   always_comb begin
      keep          = 1'b1;
      cmd_in        = cmd_ff;
      cmd_in.word_index = req_word_index;
      cmd_in.word_value = req_word_value;
      unique case (req_func)
         vpm_pkg::FUNC_WRITE: cmd_in.op = vpm_pkg::OP_WRITE;
         vpm_pkg::FUNC_ELEM:  cmd_in.op = vpm_pkg::OP_ELEM;
         vpm_pkg::FUNC_CLEAR: cmd_in.op = vpm_pkg::OP_CLEAR;
         default: begin
            // The unused code is accepted and dropped here.
            keep      = 1'b0;
            cmd_in.op = cmd_ff.op;
         end
      endcase

      if (req_valid && req_ready && keep) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && req_ready && keep) begin
         cmd_ff <= cmd_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_cmd   = cmd_ff;

endmodule

`default_nettype wire

// ===== src/vpm_queue.sv =====
// Two-entry command queue between front end and back end of the pattern
// matcher, so that each side can stall on its own. Uses vpm_pkg.
`default_nettype none

module vpm_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire vpm_pkg::cmd_type in_cmd,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output vpm_pkg::cmd_type      out_cmd
);

   localparam int DEPTH = 2;

   vpm_pkg::cmd_type entries_ff [DEPTH];
   logic             wptr_ff, wptr_in;
   logic             rptr_ff, rptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push, pop;

   assign in_ready  = (count_ff != 2'(DEPTH));
   assign out_valid = (count_ff != 2'd0);
   assign out_cmd   = entries_ff[rptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wptr_in  = push ? !wptr_ff : wptr_ff;
      rptr_in  = pop  ? !rptr_ff : rptr_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         entries_ff[wptr_ff] <= in_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== src/vpm_back.sv =====
// Back end of the pattern matcher: pattern memory, scan state and the
// result register. Uses vpm_pkg; driven by vpm_queue through the top level.
`default_nettype none

module vpm_back #(
   parameter int PATTERN_DEPTH = 64,
   parameter int MAX_DIM       = 256,
   localparam int RW  = $clog2(MAX_DIM + 1),
   localparam int MCW = $clog2(PATTERN_DEPTH + 1)
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            in_valid,
   output logic                                 in_ready,
   input  wire vpm_pkg::cmd_type                in_cmd,
   input  wire logic [RW-1:0]                   num_rows,
   input  wire logic [RW-1:0]                   num_cols,
   input  wire logic [MCW-1:0]                  pattern_len,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [vpm_pkg::OCC_W-1:0]            rsp_occurrence,
   output logic [vpm_pkg::POS_OUT_W-1:0]        rsp_start_row,
   output logic [vpm_pkg::POS_OUT_W-1:0]        rsp_start_col,
   output logic [vpm_pkg::LEN_REG_W-1:0]        rsp_match_len
);

   localparam int AW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
   localparam int CW = $clog2(MAX_DIM);

   logic [vpm_pkg::VALUE_W-1:0] pattern_mem_ff [PATTERN_DEPTH];
   logic [vpm_pkg::VALUE_W-1:0] rd_data_ff;
   logic [vpm_pkg::VALUE_W-1:0] word0_ff, word0_in;
   logic [AW-1:0]               rd_addr, wr_addr;
   logic                        wr_en;

   logic [MCW-1:0]              mc_ff, mc_in, mc_step;
   logic [RW-1:0]               row_ff, row_in;
   logic [CW-1:0]               col_ff, col_in;
   logic [CW:0]                 col_inc;
   logic [CW-1:0]               first_row_ff, first_row_in;
   logic [CW-1:0]               first_col_ff, first_col_in;
   logic [vpm_pkg::OCC_W-1:0]   total_ff, total_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [vpm_pkg::OCC_W-1:0]   occ_ff;
   logic [vpm_pkg::POS_OUT_W-1:0] srow_ff, scol_ff;
   logic [vpm_pkg::LEN_REG_W-1:0] len_out_ff;

   logic                        fire, hit, found;
   logic [vpm_pkg::VALUE_W-1:0] value;

   assign in_ready = !rsp_valid_ff || rsp_ready;
   assign fire     = in_valid && in_ready;
   assign value    = $unsigned(in_cmd.word_value);
   assign wr_addr  = AW'(in_cmd.word_index);

   always_comb begin
      mc_in        = mc_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      first_row_in = first_row_ff;
      first_col_in = first_col_ff;
      total_in     = total_ff;
      word0_in     = word0_ff;
      wr_en        = 1'b0;
      hit          = 1'b0;
      found        = 1'b0;
      mc_step      = mc_ff;
      col_inc      = {1'b0, col_ff} + 1'b1;

      if (fire) begin
         unique case (in_cmd.op)
            vpm_pkg::OP_WRITE: begin
               if (32'(in_cmd.word_index) < PATTERN_DEPTH) begin
                  wr_en = 1'b1;
                  if (wr_addr == '0) begin
                     word0_in = value;
                  end
               end
            end
            vpm_pkg::OP_CLEAR: begin
               mc_in        = '0;
               row_in       = '0;
               col_in       = '0;
               first_row_in = '0;
               first_col_in = '0;
               total_in     = '0;
            end
            vpm_pkg::OP_ELEM: begin
               if (row_ff < num_rows) begin
                  // rd_data_ff always holds the pattern word at mc_ff.
                  hit = (mc_ff < pattern_len) && (value == rd_data_ff);
                  if (hit) begin
                     if (mc_ff == '0) begin
                        first_row_in = CW'(row_ff);
                        first_col_in = col_ff;
                     end
                     mc_step = MCW'(mc_ff + 1'b1);
                  end else if (value == word0_ff) begin
                     // Restart on the current element.
                     first_row_in = CW'(row_ff);
                     first_col_in = col_ff;
                     mc_step      = MCW'(1);
                  end else begin
                     mc_step = '0;
                  end

                  if (mc_step == pattern_len) begin
                     found = 1'b1;
                     mc_in = '0;
                     if (total_ff != {vpm_pkg::OCC_W{1'b1}}) begin
                        total_in = total_ff + 1'b1;
                     end
                  end else begin
                     mc_in = mc_step;
                  end

                  if (col_inc >= num_cols) begin
                     col_in = '0;
                     row_in = RW'(row_ff + 1'b1);
                  end else begin
                     col_in = CW'(col_inc);
                  end
               end
            end
            default: begin
            end
         endcase
      end

      // Fetch the word needed for the next element in this cycle.
      rd_addr = AW'(mc_in);

      if (found) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pattern_mem_ff[wr_addr] <= value;
      end
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= value;
      end else begin
         rd_data_ff <= pattern_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mc_ff        <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         first_row_ff <= '0;
         first_col_ff <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mc_ff        <= mc_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         first_row_ff <= first_row_in;
         first_col_ff <= first_col_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      word0_ff <= word0_in;
      if (found) begin
         occ_ff     <= total_in;
         srow_ff    <= vpm_pkg::POS_OUT_W'(first_row_in);
         scol_ff    <= vpm_pkg::POS_OUT_W'(first_col_in);
         len_out_ff <= vpm_pkg::LEN_REG_W'(pattern_len);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_occurrence = occ_ff;
   assign rsp_start_row  = srow_ff;
   assign rsp_start_col  = scol_ff;
   assign rsp_match_len  = len_out_ff;

endmodule

`default_nettype wire

// ===== src/vector_pattern_matcher.sv =====
// Top level of the vector pattern matcher: configuration registers and the
// front end, queue and back end. Uses vpm_pkg, vpm_front, vpm_queue, vpm_back.
//
// The block takes one request item per clock cycle, back to back, while
// nothing stalls, and gives at most one result per element item. An item
// passes a decode register, a two-entry queue and the back end, whose
// result register holds the result. The sustained rate of one item
// per cycle is set by the match loop in the back end: each element compares
// against a pattern word that the registered memory read fetched in the
// previous cycle, addressed by that cycle's next match count. Configuration
// writes are always taken and must only happen while the block is idle.
// Pattern words never written read back as unknown; no clearing pass runs.
`default_nettype none

module vector_pattern_matcher #(
   parameter int PATTERN_DEPTH = 64,
   parameter int MAX_DIM       = 256
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [vpm_pkg::FUNC_W-1:0]          req_func,
   input  wire logic [vpm_pkg::INDEX_W-1:0]         req_word_index,
   input  wire logic signed [vpm_pkg::VALUE_W-1:0]  req_word_value,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [vpm_pkg::OCC_W-1:0]                rsp_occurrence,
   output logic [vpm_pkg::POS_OUT_W-1:0]            rsp_start_row,
   output logic [vpm_pkg::POS_OUT_W-1:0]            rsp_start_col,
   output logic [vpm_pkg::LEN_REG_W-1:0]            rsp_match_len,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [vpm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [vpm_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int RW  = $clog2(MAX_DIM + 1);
   localparam int MCW = $clog2(PATTERN_DEPTH + 1);

   logic [vpm_pkg::DIM_REG_W-1:0] rows_ff, rows_in;
   logic [vpm_pkg::DIM_REG_W-1:0] cols_ff, cols_in;
   logic [vpm_pkg::LEN_REG_W-1:0] len_ff, len_in;
   logic [RW-1:0]                 rows_clamped, cols_clamped;
   logic [MCW-1:0]                len_clamped;

   logic             front_valid, front_ready;
   vpm_pkg::cmd_type front_cmd;
   logic             back_valid, back_ready;
   vpm_pkg::cmd_type back_cmd;

   assign csr_ready = 1'b1;

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      len_in  = len_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            vpm_pkg::CSR_NUM_ROWS:    rows_in = csr_data;
            vpm_pkg::CSR_NUM_COLS:    cols_in = csr_data;
            vpm_pkg::CSR_PATTERN_LEN: len_in  = vpm_pkg::LEN_REG_W'(csr_data);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= vpm_pkg::NUM_ROWS_RESET;
         cols_ff <= vpm_pkg::NUM_COLS_RESET;
         len_ff  <= vpm_pkg::PATTERN_LEN_RESET;
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
         len_ff  <= len_in;
      end
   end

   // Out-of-range settings are clamped into the supported range.
   always_comb begin
      if (rows_ff == '0) begin
         rows_clamped = RW'(1);
      end else if (32'(rows_ff) > MAX_DIM) begin
         rows_clamped = RW'(MAX_DIM);
      end else begin
         rows_clamped = RW'(rows_ff);
      end
      if (cols_ff == '0) begin
         cols_clamped = RW'(1);
      end else if (32'(cols_ff) > MAX_DIM) begin
         cols_clamped = RW'(MAX_DIM);
      end else begin
         cols_clamped = RW'(cols_ff);
      end
      if (len_ff == '0) begin
         len_clamped = MCW'(1);
      end else if (32'(len_ff) > PATTERN_DEPTH) begin
         len_clamped = MCW'(PATTERN_DEPTH);
      end else begin
         len_clamped = MCW'(len_ff);
      end
   end

   vpm_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_word_index (req_word_index),
      .req_word_value (req_word_value),
      .out_valid      (front_valid),
      .out_ready      (front_ready),
      .out_cmd        (front_cmd)
   );

   vpm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_cmd    (front_cmd),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_cmd   (back_cmd)
   );

   vpm_back #(
      .PATTERN_DEPTH (PATTERN_DEPTH),
      .MAX_DIM       (MAX_DIM)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (back_valid),
      .in_ready       (back_ready),
      .in_cmd         (back_cmd),
      .num_rows       (rows_clamped),
      .num_cols       (cols_clamped),
      .pattern_len    (len_clamped),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_occurrence (rsp_occurrence),
      .rsp_start_row  (rsp_start_row),
      .rsp_start_col  (rsp_start_col),
      .rsp_match_len  (rsp_match_len)
   );

`ifndef SYNTH
   // A decoded item waiting on a full queue must not change.
   assert property (@(posedge clock) disable iff (reset)
      front_valid && !front_ready |=> front_valid && $stable(front_cmd))
      else $error("front end dropped or changed a stalled item");

   // Occurrence numbers start at one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_occurrence != '0)
      else $error("result with zero occurrence number");

   // The reported length always lies in the clamped pattern range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_match_len != '0) && (32'(rsp_match_len) <= PATTERN_DEPTH))
      else $error("result with out-of-range match length");

   // The back end stalls only behind a result that is not taken.
   assert property (@(posedge clock) disable iff (reset)
      !back_ready |-> rsp_valid && !rsp_ready)
      else $error("back end stalled without a pending result");
`endif

endmodule

`default_nettype wire
